// ===== hw/rtl/rational_normalize_compare_macros.svh =====
// Assertion helpers shared by the checker
`ifndef RATIONAL_NORMALIZE_COMPARE_MACROS_SVH
`define RATIONAL_NORMALIZE_COMPARE_MACROS_SVH
// Check that a condition holds on every clock edge out of reset
`define RNC_ASSERT(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
// Check that an antecedent implies a consequent on the next edge
`define RNC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hw/rtl/rnc_pkg.sv =====
package rnc_pkg;
    localparam int WORD_BITS_DEF = 32;
    localparam int NUM_LANES     = 2;
endpackage

// ===== hw/rtl/rnc_lane.sv =====
// One fraction lane: magnitudes, Euclid gcd by restoring division, then two
// quotients by the same divider. One quotient bit per cycle.
module rnc_lane #(
    parameter int WORD_BITS = rnc_pkg::WORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] num_in,
    input  logic [WORD_BITS-1:0] den_in,
    output logic                 done,
    output logic                 neg,
    output logic                 zero,
    output logic [WORD_BITS-1:0] mag,
    output logic [WORD_BITS-1:0] den
);
    localparam int CW = $clog2(WORD_BITS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_QN   = 5'b00100,
        S_QD   = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [WORD_BITS-1:0] p_reg, q_reg, nm_reg, dm_reg;
    logic [WORD_BITS-1:0] rem_reg, quo_reg, dvd_reg;
    logic [WORD_BITS-1:0] mag_reg, den_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 neg_reg, zero_reg;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS-1:0] rem_new, quo_new, dvsr;
    logic                 last;

    // Restoring divide step on the shared divider
    assign dvsr    = (state_reg == S_GCD) ? q_reg : p_reg;
    assign trial   = {rem_reg, dvd_reg[WORD_BITS-1]} - {1'b0, dvsr};
    assign rem_new = trial[WORD_BITS] ? {rem_reg[WORD_BITS-2:0], dvd_reg[WORD_BITS-1]}
                                      : trial[WORD_BITS-1:0];
    assign quo_new = {quo_reg[WORD_BITS-2:0], ~trial[WORD_BITS]};
    assign last    = (cnt_reg == CW'(WORD_BITS - 1));

    // Hold in the done state with the answer until the next item starts
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_GCD;
            S_GCD:  if (q_reg == '0) state_next = S_QN;
            S_QN:   if (last) state_next = S_QD;
            S_QD:   if (last) state_next = S_DONE;
            S_DONE: if (start) state_next = S_GCD;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath: load magnitudes, iterate gcd, then divide both parts by it
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE, S_DONE: begin
                if (start) begin
                    nm_reg   <= num_in[WORD_BITS-1] ? (~num_in + 1'b1) : num_in;
                    dm_reg   <= den_in[WORD_BITS-1] ? (~den_in + 1'b1) : den_in;
                    p_reg    <= num_in[WORD_BITS-1] ? (~num_in + 1'b1) : num_in;
                    q_reg    <= den_in[WORD_BITS-1] ? (~den_in + 1'b1) : den_in;
                    neg_reg  <= num_in[WORD_BITS-1] ^ den_in[WORD_BITS-1];
                    zero_reg <= (num_in == '0);
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    cnt_reg  <= '0;
                    dvd_reg  <= num_in[WORD_BITS-1] ? (~num_in + 1'b1) : num_in;
                end
            end
            S_GCD: begin
                if (q_reg == '0) begin
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    dvd_reg <= nm_reg;
                end else if (last) begin
                    p_reg   <= q_reg;
                    q_reg   <= rem_new;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    dvd_reg <= q_reg;
                end else begin
                    rem_reg <= rem_new;
                    dvd_reg <= {dvd_reg[WORD_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            S_QN, S_QD: begin
                quo_reg <= quo_new;
                if (last) begin
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    dvd_reg <= dm_reg;
                    if (state_reg == S_QN) mag_reg <= quo_new;
                    else den_reg <= quo_new;
                end else begin
                    rem_reg <= rem_new;
                    dvd_reg <= {dvd_reg[WORD_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign done = (state_reg == S_DONE);
    assign neg  = neg_reg & ~zero_reg;
    assign zero = zero_reg;
    assign mag  = zero_reg ? '0 : mag_reg;
    assign den  = zero_reg ? WORD_BITS'(1) : den_reg;
endmodule

// ===== hw/rtl/rnc_merge.sv =====
// Merge stage: cross products, ordering and equality, output formatting
module rnc_merge #(
    parameter int WORD_BITS = rnc_pkg::WORD_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   start,
    input  logic                   err,
    input  logic                   a_neg,
    input  logic                   a_zero,
    input  logic [WORD_BITS-1:0]   a_mag,
    input  logic [WORD_BITS-1:0]   a_den,
    input  logic                   b_neg,
    input  logic                   b_zero,
    input  logic [WORD_BITS-1:0]   b_mag,
    input  logic [WORD_BITS-1:0]   b_den,
    output logic [4*WORD_BITS:0]   result
);
    localparam logic [WORD_BITS-1:0] DMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    logic [2*WORD_BITS-1:0] p1_reg, p2_reg;
    logic [1:0]             sa, sb;
    logic                   lt, eq;
    logic [WORD_BITS-1:0]   an, bn, ad, bd;

    // Register the two cross products
    always_ff @(posedge aclk) begin
        if (start) begin
            p1_reg <= a_mag * b_den;
            p2_reg <= b_mag * a_den;
        end
    end

    // Sign codes: 0 negative, 1 zero, 2 positive
    assign sa = a_zero ? 2'd1 : (a_neg ? 2'd0 : 2'd2);
    assign sb = b_zero ? 2'd1 : (b_neg ? 2'd0 : 2'd2);
    assign lt = (sa != sb) ? (sa < sb) : (sa == 2'd1) ? 1'b0 :
                (sa == 2'd2) ? (p1_reg < p2_reg) : (p1_reg > p2_reg);
    assign eq = (sa == sb) && (a_mag == b_mag) && (a_den == b_den);
    assign an = a_neg ? (~a_mag + 1'b1) : ((a_mag > DMAX) ? DMAX : a_mag);
    assign bn = b_neg ? (~b_mag + 1'b1) : ((b_mag > DMAX) ? DMAX : b_mag);
    assign ad = (a_den > DMAX) ? DMAX : a_den;
    assign bd = (b_den > DMAX) ? DMAX : b_den;

    assign result = err ? {1'b1, {(4*WORD_BITS){1'b0}}}
                        : {1'b0, eq, lt, bd[WORD_BITS-2:0], bn, ad[WORD_BITS-2:0], an};
endmodule

// ===== hw/rtl/rational_normalize_compare.sv =====
// Channel  | Dir | Payload
// s_axis   | in  | a_num, a_den, b_num, b_den (tdata)
// m_axis   | out | a_red_num, a_red_den, b_red_num, b_red_den, a_less, a_equal, den_error
// One item at a time. The time from input transfer to result grows with k,
// the Euclid remainder steps of the slower lane (at least one), each done
// bit by bit by the per-lane shift divider.
// A zero denominator skips the lanes and goes straight to the output register.
// Reset is synchronous, active low. A held result does not block the next
// item from being taken; a second result waits until the first is taken.
module rational_normalize_compare #(
    parameter int WORD_BITS = rnc_pkg::WORD_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // a_num, a_den, b_num, b_den from bit 0 up
    input  logic [4*WORD_BITS-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // a_red_num, a_red_den, b_red_num, b_red_den, a_less, a_equal, den_error
    output logic [((4*WORD_BITS+1)+7)/8*8-1:0] m_axis_tdata
);
    localparam int RW = 4*WORD_BITS + 1;
    localparam int OW = (RW + 7) / 8 * 8;

    logic busy_reg, err_reg, mstart_reg, pend_reg, run_reg;
    logic [RW-1:0] out_reg;
    logic [rnc_pkg::NUM_LANES-1:0] done_w;
    logic [rnc_pkg::NUM_LANES-1:0] neg_w, zero_w;
    logic [WORD_BITS-1:0] mag_w [rnc_pkg::NUM_LANES];
    logic [WORD_BITS-1:0] den_w [rnc_pkg::NUM_LANES];
    logic [RW-1:0] res_w;
    logic take, start;
    logic zden;
    logic all_done, ld_out;

    assign zden  = (s_axis_tdata[2*WORD_BITS-1:WORD_BITS] == '0) ||
                   (s_axis_tdata[4*WORD_BITS-1:3*WORD_BITS] == '0);
    assign s_axis_tready = !busy_reg;
    assign take  = s_axis_tvalid && s_axis_tready;
    assign start = take && !zden;
    assign all_done = &done_w;
    assign ld_out   = pend_reg && (!m_axis_tvalid || m_axis_tready);

    genvar i;
    generate
        for (i = 0; i < rnc_pkg::NUM_LANES; i++) begin : g_lane
            rnc_lane #(.WORD_BITS(WORD_BITS)) u_lane (
                .aclk(aclk), .aresetn(aresetn), .start(start),
                .num_in(s_axis_tdata[(2*i)*WORD_BITS +: WORD_BITS]),
                .den_in(s_axis_tdata[(2*i+1)*WORD_BITS +: WORD_BITS]),
                .done(done_w[i]), .neg(neg_w[i]), .zero(zero_w[i]),
                .mag(mag_w[i]), .den(den_w[i]));
        end
    endgenerate

    rnc_merge #(.WORD_BITS(WORD_BITS)) u_merge (
        .aclk(aclk), .start(all_done), .err(err_reg),
        .a_neg(neg_w[0]), .a_zero(zero_w[0]), .a_mag(mag_w[0]), .a_den(den_w[0]),
        .b_neg(neg_w[1]), .b_zero(zero_w[1]), .b_mag(mag_w[1]), .b_den(den_w[1]),
        .result(res_w));

    // Sequence: lanes done, products registered, then load output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            mstart_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            run_reg       <= 1'b0;
            m_axis_tvalid <= 1'b0;
            err_reg       <= 1'b0;
        end else begin
            mstart_reg <= run_reg && all_done;
            // Track the item while the lanes run
            if (take) begin
                err_reg <= zden;
                run_reg <= !zden;
            end else if (run_reg && all_done) begin
                run_reg <= 1'b0;
            end
            if (take) begin
                pend_reg <= zden;
            end else if (mstart_reg) begin
                pend_reg <= 1'b1;
            end else if (ld_out) begin
                pend_reg <= 1'b0;
            end
            if (take) begin
                busy_reg <= 1'b1;
            end else if (ld_out) begin
                busy_reg <= 1'b0;
            end
            // Load the result, or drop valid once the transfer is taken
            if (ld_out) begin
                out_reg       <= res_w;
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end

    assign m_axis_tdata = OW'(out_reg);
endmodule

// ===== hw/rtl/rnc_checker.sv =====
`include "rational_normalize_compare_macros.svh"
// Port-level checks for the top level
module rnc_checker #(
    parameter int WORD_BITS = rnc_pkg::WORD_BITS_DEF
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [((4*WORD_BITS+1)+7)/8*8-1:0] m_axis_tdata
);
    localparam int EB = 4*WORD_BITS;
    `RNC_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `RNC_ASSERT_NEXT(a_one, aclk, aresetn, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "second item taken while busy")
    `RNC_ASSERT(a_err, aclk, aresetn,
        !(m_axis_tvalid && m_axis_tdata[EB]) || (m_axis_tdata[EB-1:0] == '0),
        "error result carries data")
endmodule

bind rational_normalize_compare rnc_checker #(.WORD_BITS(WORD_BITS)) u_rnc_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));
